// ===== hw/rtl/latb_pkg.sv =====
// Shared types, key codes and port widths of the line-array text buffer.
package latb_pkg;

  localparam int KEY_W   = 9;
  localparam int LINE_W  = 7;
  localparam int COL_W   = 7;
  localparam int TOTAL_W = 8;
  localparam int CHAR_W  = 8;

  localparam logic [KEY_W-1:0] KEY_BS    = 9'h008;
  localparam logic [KEY_W-1:0] KEY_NL    = 9'h00A;
  localparam logic [KEY_W-1:0] PRINT_LO  = 9'h020;
  localparam logic [KEY_W-1:0] PRINT_END = 9'h07F;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 9'h100;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 9'h101;
  localparam logic [KEY_W-1:0] KEY_UP    = 9'h102;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 9'h103;
  localparam logic [KEY_W-1:0] KEY_HOME  = 9'h104;
  localparam logic [KEY_W-1:0] KEY_END   = 9'h105;
  localparam logic [KEY_W-1:0] KEY_DEL   = 9'h109;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_CUR,
    ST_NBR,
    ST_EXEC,
    ST_SH_RD,
    ST_SH_WR,
    ST_TAIL,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/latb_if.sv =====
// Valid/ready channel interfaces for the key input and the result output.
interface latb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [latb_pkg::KEY_W-1:0]   key;
  logic [latb_pkg::LINE_W-1:0]  read_line;
  logic [latb_pkg::COL_W-1:0]   read_col;

  modport source (output valid, func, key, read_line, read_col, input ready);
  modport sink   (input valid, func, key, read_line, read_col, output ready);
endinterface

interface latb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [latb_pkg::LINE_W-1:0]  caret_line;
  logic [latb_pkg::COL_W-1:0]   caret_col;
  logic [latb_pkg::TOTAL_W-1:0] line_total;
  logic                         modified;
  logic [latb_pkg::CHAR_W-1:0]  read_char;

  modport source (output valid, status, caret_line, caret_col, line_total, modified,
                  read_char, input ready);
  modport sink   (input valid, status, caret_line, caret_col, line_total, modified,
                  read_char, output ready);
endinterface

// ===== hw/rtl/latb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module latb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/line_array_text_buffer.sv =====
// Top level of the line-array text buffer: row memory, sequencer and result register.
// A read word or a simple key passes through FETCH, CUR, NBR, EXEC and DONE once accepted;
// a split or a join also moves each following line through the row memory, with a read state
// SH_RD and a write state SH_WR for each line, so the shift loop sets the length of such a word.
// One word is in work at a time; the next is accepted once the sequencer is idle again.
// Reset (rst_n low, synchronous) clears the caret and the dirty mark, sets the line count to 1;
// the INIT state after reset writes an empty line 0, and no word is accepted in that state.
module line_array_text_buffer #(
  parameter int MAX_LINES     = 128,
  parameter int LINE_CAPACITY = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  latb_in_if.sink    in_ch,
  latb_out_if.source out_ch
);

  // Each row of the memory holds a whole line: its bytes and, on top, its length.
  localparam int LW      = $clog2(MAX_LINES);
  localparam int CW      = $clog2(MAX_LINES + 1);
  localparam int LEN_W   = $clog2(LINE_CAPACITY);
  localparam int MAX_LEN = LINE_CAPACITY - 1;
  localparam int RW      = LINE_CAPACITY * 8 + LEN_W;

  latb_pkg::state_t state_r, state_nxt;

  // The word in work.
  logic                         func_r, func_nxt;
  logic [latb_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [latb_pkg::LINE_W-1:0]  rl_r, rl_nxt;
  logic [latb_pkg::COL_W-1:0]   rc_r, rc_nxt;

  // Editor state kept in flip-flops.
  logic [LW-1:0]    cr_r, cr_nxt;
  logic [LEN_W-1:0] cc_r, cc_nxt;
  logic [CW-1:0]    lc_r, lc_nxt;
  logic             dirty_r, dirty_nxt;

  // Working rows: the caret row and its neighbour; the neighbour register also
  // carries the tail of a split line until it is written.
  logic [RW-1:0] cur_r, cur_nxt;
  logic [RW-1:0] nbr_r, nbr_nxt;

  logic             status_r, status_nxt;
  logic [7:0]       rch_r, rch_nxt;

  // Line shift engine: destination index, last destination and direction.
  logic [LW-1:0] sh_idx_r, sh_idx_nxt;
  logic [LW-1:0] sh_end_r, sh_end_nxt;
  logic          sh_up_r, sh_up_nxt;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic                         o_status_r, o_status_nxt;
  logic [latb_pkg::LINE_W-1:0]  o_line_r, o_line_nxt;
  logic [latb_pkg::COL_W-1:0]   o_col_r, o_col_nxt;
  logic [latb_pkg::TOTAL_W-1:0] o_total_r, o_total_nxt;
  logic                         o_mod_r, o_mod_nxt;
  logic [latb_pkg::CHAR_W-1:0]  o_char_r, o_char_nxt;

  // Row memory.
  logic          ram_we;
  logic [LW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  latb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_LINES)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Unpacked views of the working rows.
  logic [7:0]       cur_b [LINE_CAPACITY];
  logic [7:0]       nbr_b [LINE_CAPACITY];
  logic [LEN_W-1:0] cur_len, nbr_len;

  always_comb begin
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      cur_b[i] = cur_r[i*8 +: 8];
      nbr_b[i] = nbr_r[i*8 +: 8];
    end
    cur_len = cur_r[RW-1 -: LEN_W];
    nbr_len = nbr_r[RW-1 -: LEN_W];
  end

  // Key classes.
  logic is_print, is_bs, is_del, is_nl, is_up, is_down;

  always_comb begin
    is_print = (key_r >= latb_pkg::PRINT_LO) && (key_r < latb_pkg::PRINT_END);
    is_bs    = (key_r == latb_pkg::KEY_BS);
    is_del   = (key_r == latb_pkg::KEY_DEL);
    is_nl    = (key_r == latb_pkg::KEY_NL);
    is_up    = (key_r == latb_pkg::KEY_UP);
    is_down  = (key_r == latb_pkg::KEY_DOWN);
  end

  // Row edits. Each byte of a new row picks its source independently.
  logic [7:0]       ins_b  [LINE_CAPACITY];
  logic [7:0]       era_b  [LINE_CAPACITY];
  logic [7:0]       join_b [LINE_CAPACITY];
  logic [7:0]       tail_b [LINE_CAPACITY];
  logic [LEN_W-1:0] era_pos, join_a;
  logic [LEN_W:0]   join_sum;
  logic [RW-1:0]    ins_row, era_row, join_row, tail_row, pre_row;
  logic [7:0]       rd_byte;

  always_comb begin
    era_pos  = is_bs ? (cc_r - LEN_W'(1)) : cc_r;
    join_a   = is_bs ? nbr_len : cur_len;
    join_sum = {1'b0, cur_len} + {1'b0, nbr_len};
    rd_byte  = 8'd0;
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      if (i < int'(cc_r)) begin
        ins_b[i] = cur_b[i];
      end else if (i == int'(cc_r)) begin
        ins_b[i] = key_r[7:0];
      end else begin
        ins_b[i] = cur_b[(i > 0) ? i - 1 : 0];
      end
      if (i < int'(era_pos)) begin
        era_b[i] = cur_b[i];
      end else begin
        era_b[i] = (i + 1 < LINE_CAPACITY) ? cur_b[(i + 1 < LINE_CAPACITY) ? i + 1 : i]
                                           : 8'd0;
      end
      if (i < int'(join_a)) begin
        join_b[i] = is_bs ? nbr_b[i] : cur_b[i];
      end else begin
        join_b[i] = is_bs ? cur_b[i - int'(join_a)] : nbr_b[i - int'(join_a)];
      end
      if (i + int'(cc_r) < LINE_CAPACITY) begin
        tail_b[i] = cur_b[(i + int'(cc_r) < LINE_CAPACITY) ? i + int'(cc_r) : i];
      end else begin
        tail_b[i] = 8'd0;
      end
      if (i == int'(rc_r)) begin
        rd_byte = cur_b[i];
      end
    end
    for (int i = 0; i < LINE_CAPACITY; i++) begin
      ins_row[i*8 +: 8]  = ins_b[i];
      era_row[i*8 +: 8]  = era_b[i];
      join_row[i*8 +: 8] = join_b[i];
      tail_row[i*8 +: 8] = tail_b[i];
      pre_row[i*8 +: 8]  = cur_b[i];
    end
    ins_row[RW-1 -: LEN_W]  = cur_len + LEN_W'(1);
    era_row[RW-1 -: LEN_W]  = cur_len - LEN_W'(1);
    join_row[RW-1 -: LEN_W] = join_sum[LEN_W-1:0];
    tail_row[RW-1 -: LEN_W] = cur_len - cc_r;
    pre_row[RW-1 -: LEN_W]  = cc_r;
  end

  // Caret neighbours, checked against the line count.
  logic          has_above, has_below;
  logic [LW-1:0] nbr_idx;

  always_comb begin
    has_above = (cr_r != '0);
    has_below = ((CW'(cr_r) + CW'(1)) < lc_r);
    if (is_up || is_bs) begin
      nbr_idx = has_above ? (cr_r - LW'(1)) : cr_r;
    end else begin
      nbr_idx = has_below ? (cr_r + LW'(1)) : cr_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      latb_pkg::ST_INIT:  state_nxt = latb_pkg::ST_IDLE;
      latb_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = latb_pkg::ST_FETCH;
      latb_pkg::ST_FETCH: state_nxt = latb_pkg::ST_CUR;
      latb_pkg::ST_CUR:   state_nxt = latb_pkg::ST_NBR;
      latb_pkg::ST_NBR:   state_nxt = latb_pkg::ST_EXEC;
      latb_pkg::ST_EXEC: begin
        state_nxt = latb_pkg::ST_DONE;
        if (func_r == latb_pkg::FUNC_KEY) begin
          if (is_nl && (lc_r < CW'(MAX_LINES))) begin
            state_nxt = has_below ? latb_pkg::ST_SH_RD : latb_pkg::ST_TAIL;
          end else if (is_bs && (cc_r == '0) && has_above && (join_sum < MAX_LEN)) begin
            state_nxt = has_below ? latb_pkg::ST_SH_RD : latb_pkg::ST_DONE;
          end else if (is_del && (cc_r >= cur_len) && has_below && (join_sum < MAX_LEN)) begin
            state_nxt = ((CW'(cr_r) + CW'(2)) < lc_r) ? latb_pkg::ST_SH_RD
                                                      : latb_pkg::ST_DONE;
          end
        end
      end
      latb_pkg::ST_SH_RD: state_nxt = latb_pkg::ST_SH_WR;
      latb_pkg::ST_SH_WR: begin
        if (sh_idx_r != sh_end_r) begin
          state_nxt = latb_pkg::ST_SH_RD;
        end else begin
          state_nxt = sh_up_r ? latb_pkg::ST_DONE : latb_pkg::ST_TAIL;
        end
      end
      latb_pkg::ST_TAIL:  state_nxt = latb_pkg::ST_DONE;
      latb_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = latb_pkg::ST_IDLE;
      default:            state_nxt = latb_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory control and result register.
  always_comb begin
    func_nxt   = func_r;
    key_nxt    = key_r;
    rl_nxt     = rl_r;
    rc_nxt     = rc_r;
    cr_nxt     = cr_r;
    cc_nxt     = cc_r;
    lc_nxt     = lc_r;
    dirty_nxt  = dirty_r;
    cur_nxt    = cur_r;
    nbr_nxt    = nbr_r;
    status_nxt = status_r;
    rch_nxt    = rch_r;
    sh_idx_nxt = sh_idx_r;
    sh_end_nxt = sh_end_r;
    sh_up_nxt  = sh_up_r;
    ram_we     = 1'b0;
    ram_waddr  = cr_r;
    ram_wdata  = cur_r;
    ram_raddr  = cr_r;

    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_line_nxt    = o_line_r;
    o_col_nxt     = o_col_r;
    o_total_nxt   = o_total_r;
    o_mod_nxt     = o_mod_r;
    o_char_nxt    = o_char_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    in_ch.ready = (state_r == latb_pkg::ST_IDLE);

    unique case (state_r)
      latb_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
      end
      latb_pkg::ST_IDLE: begin
        func_nxt = in_ch.func;
        key_nxt  = in_ch.key;
        rl_nxt   = in_ch.read_line;
        rc_nxt   = in_ch.read_col;
      end
      latb_pkg::ST_FETCH: begin
        if (func_r == latb_pkg::FUNC_READ) begin
          ram_raddr = (int'(rl_r) < MAX_LINES) ? LW'(rl_r) : '0;
        end
      end
      latb_pkg::ST_CUR: begin
        cur_nxt   = ram_rdata;
        ram_raddr = nbr_idx;
      end
      latb_pkg::ST_NBR: begin
        nbr_nxt = ram_rdata;
      end
      latb_pkg::ST_EXEC: begin
        status_nxt = 1'b0;
        rch_nxt    = 8'd0;
        if (func_r == latb_pkg::FUNC_READ) begin
          if ((int'(rl_r) < int'(lc_r)) && (int'(rc_r) < int'(cur_len))) begin
            rch_nxt = rd_byte;
          end
        end else if (is_print) begin
          if (cur_len >= LEN_W'(MAX_LEN)) begin
            status_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ins_row;
            cc_nxt    = cc_r + LEN_W'(1);
            dirty_nxt = 1'b1;
          end
        end else if (is_nl) begin
          if (lc_r >= CW'(MAX_LINES)) begin
            status_nxt = 1'b1;
          end else begin
            // Cut the caret row here; lines below move down one row, then the tail lands.
            ram_we     = 1'b1;
            ram_wdata  = pre_row;
            nbr_nxt    = tail_row;
            sh_up_nxt  = 1'b0;
            sh_idx_nxt = LW'(lc_r);
            sh_end_nxt = cr_r + LW'(2);
            lc_nxt     = lc_r + CW'(1);
            cr_nxt     = cr_r + LW'(1);
            cc_nxt     = '0;
            dirty_nxt  = 1'b1;
          end
        end else if (is_bs) begin
          if (cc_r != '0) begin
            ram_we    = 1'b1;
            ram_wdata = era_row;
            cc_nxt    = cc_r - LEN_W'(1);
            dirty_nxt = 1'b1;
          end else if (has_above) begin
            if (join_sum >= MAX_LEN) begin
              status_nxt = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = cr_r - LW'(1);
              ram_wdata  = join_row;
              sh_up_nxt  = 1'b1;
              sh_idx_nxt = cr_r;
              sh_end_nxt = LW'(lc_r - CW'(2));
              lc_nxt     = lc_r - CW'(1);
              cr_nxt     = cr_r - LW'(1);
              cc_nxt     = nbr_len;
              dirty_nxt  = 1'b1;
            end
          end
        end else if (is_del) begin
          if (cc_r < cur_len) begin
            ram_we    = 1'b1;
            ram_wdata = era_row;
            dirty_nxt = 1'b1;
          end else if (has_below) begin
            if (join_sum >= MAX_LEN) begin
              status_nxt = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_wdata  = join_row;
              sh_up_nxt  = 1'b1;
              sh_idx_nxt = cr_r + LW'(1);
              sh_end_nxt = LW'(lc_r - CW'(2));
              lc_nxt     = lc_r - CW'(1);
              dirty_nxt  = 1'b1;
            end
          end
        end else begin
          case (key_r) inside
            latb_pkg::KEY_LEFT:  if (cc_r != '0) cc_nxt = cc_r - LEN_W'(1);
            latb_pkg::KEY_RIGHT: if (cc_r < cur_len) cc_nxt = cc_r + LEN_W'(1);
            latb_pkg::KEY_UP, latb_pkg::KEY_DOWN: begin
              if ((is_up && has_above) || (is_down && has_below)) begin
                cr_nxt = nbr_idx;
                if (cc_r > nbr_len) cc_nxt = nbr_len;
              end
            end
            latb_pkg::KEY_HOME:  cc_nxt = '0;
            latb_pkg::KEY_END:   cc_nxt = cur_len;
            default:             cc_nxt = cc_r;
          endcase
        end
      end
      latb_pkg::ST_SH_RD: begin
        ram_raddr = sh_up_r ? (sh_idx_r + LW'(1)) : (sh_idx_r - LW'(1));
      end
      latb_pkg::ST_SH_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = sh_idx_r;
        ram_wdata  = ram_rdata;
        sh_idx_nxt = sh_up_r ? (sh_idx_r + LW'(1)) : (sh_idx_r - LW'(1));
      end
      latb_pkg::ST_TAIL: begin
        // The caret already stands on the new line.
        ram_we    = 1'b1;
        ram_waddr = cr_r;
        ram_wdata = nbr_r;
      end
      latb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_line_nxt    = latb_pkg::LINE_W'(cr_r);
          o_col_nxt     = latb_pkg::COL_W'(cc_r);
          o_total_nxt   = latb_pkg::TOTAL_W'(lc_r);
          o_mod_nxt     = dirty_r;
          o_char_nxt    = rch_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= latb_pkg::ST_INIT;
      cr_r        <= '0;
      cc_r        <= '0;
      lc_r        <= CW'(1);
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cr_r        <= cr_nxt;
      cc_r        <= cc_nxt;
      lc_r        <= lc_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    rl_r       <= rl_nxt;
    rc_r       <= rc_nxt;
    cur_r      <= cur_nxt;
    nbr_r      <= nbr_nxt;
    status_r   <= status_nxt;
    rch_r      <= rch_nxt;
    sh_idx_r   <= sh_idx_nxt;
    sh_end_r   <= sh_end_nxt;
    sh_up_r    <= sh_up_nxt;
    o_status_r <= o_status_nxt;
    o_line_r   <= o_line_nxt;
    o_col_r    <= o_col_nxt;
    o_total_r  <= o_total_nxt;
    o_mod_r    <= o_mod_nxt;
    o_char_r   <= o_char_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = o_status_r;
  assign out_ch.caret_line = o_line_r;
  assign out_ch.caret_col  = o_col_r;
  assign out_ch.line_total = o_total_r;
  assign out_ch.modified   = o_mod_r;
  assign out_ch.read_char  = o_char_r;

endmodule

// ===== hw/rtl/latb_checker.sv =====
// Port-level assertions for the line-array text buffer and their bind.
module latb_checker #(
  parameter int MAX_LINES     = 128,
  parameter int LINE_CAPACITY = 96
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [latb_pkg::LINE_W-1:0]  caret_line,
  input logic [latb_pkg::COL_W-1:0]   caret_col,
  input logic [latb_pkg::TOTAL_W-1:0] line_total,
  input logic                         modified
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(caret_line) && $stable(line_total))
    else $error("result word dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (line_total != 0) && (int'(line_total) <= MAX_LINES))
    else $error("line count out of range");

  a_caret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (caret_line < line_total) && (int'(caret_col) < LINE_CAPACITY))
    else $error("caret beyond the buffer");

  a_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && modified |=> !out_valid || modified)
    else $error("dirty mark cleared without reset");

endmodule

bind line_array_text_buffer latb_checker #(
  .MAX_LINES     (MAX_LINES),
  .LINE_CAPACITY (LINE_CAPACITY)
) u_latb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .caret_line (out_ch.caret_line),
  .caret_col  (out_ch.caret_col),
  .line_total (out_ch.line_total),
  .modified   (out_ch.modified)
);
